// File: design/laplacian_stencil_entry_generator_assert.svh
// ---------------------------------------------------------------------------
// Laplacian stencil entry generator - assertion macros
// Concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef LAPLACIAN_STENCIL_ENTRY_GENERATOR_ASSERT_SVH
`define LAPLACIAN_STENCIL_ENTRY_GENERATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define LSG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define LSG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LSG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define LSG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: design/lsg_pkg.sv
// ---------------------------------------------------------------------------
// Laplacian stencil entry generator - package
// Field widths, stage payload types and the remainder step.
// ---------------------------------------------------------------------------
`default_nettype none

package lsg_pkg;

  localparam int unsigned COL_W    = 18;  // column / row index
  localparam int unsigned SIDE_W   = 7;   // grid side n
  localparam int unsigned SQ_W     = 2 * SIDE_W;   // n*n
  localparam int unsigned CUBE_W   = 3 * SIDE_W;   // n*n*n
  localparam int unsigned SUM_W    = CUBE_W + 1;   // compare headroom
  localparam int unsigned VAL_W    = 4;
  localparam int unsigned SLOTS    = 7;   // center plus six neighbors
  localparam int unsigned STEPS    = 3;   // remainder steps per stage
  localparam int unsigned MOD_STAGES = COL_W / STEPS;

  localparam logic signed [VAL_W-1:0] CENTER_2D    = 4'sd4;
  localparam logic signed [VAL_W-1:0] CENTER_3D    = 4'sd6;
  localparam logic signed [VAL_W-1:0] NEIGHBOR_VAL = -4'sd1;
  localparam logic signed [VAL_W-1:0] BAD_VAL      = 4'sd0;

  typedef enum logic [0:0] {
    CFG_GRID_SIDE = 1'b0,
    CFG_DIMS_MODE = 1'b1
  } cfg_idx_e;

  // payload carried down the remainder pipeline
  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [SIDE_W-1:0] n;
    logic [SQ_W-1:0]   nn;
    logic [CUBE_W-1:0] nnn;
    logic              three;
    logic [SIDE_W-1:0] rem_n;
    logic [SQ_W-1:0]   rem_nn;
  } pipe_t;

  // one classified column, ready for the emitter
  typedef struct packed {
    logic [COL_W-1:0]              col;
    logic                          bad;
    logic signed [VAL_W-1:0]       center;
    logic [SLOTS-1:0]              mask;
    logic [SLOTS-1:0][COL_W-1:0]   rows;
  } item_t;

  // one restoring remainder step: shift in a bit, subtract if it fits
  function automatic logic [SQ_W-1:0] mod_step(input logic [SQ_W-1:0] r,
                                               input logic            b,
                                               input logic [SQ_W-1:0] d);
    logic [SQ_W:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[SQ_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: design/lsg_if.sv
// ---------------------------------------------------------------------------
// Laplacian stencil entry generator - stream interfaces
// Column input channel and entry output channel, valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface lsg_in_if;
  logic                         valid;
  logic                         ready;
  logic [lsg_pkg::COL_W-1:0]    column_index;

  modport source (output valid, output column_index, input ready);
  modport sink   (input valid, input column_index, output ready);
endinterface

interface lsg_out_if;
  logic                              valid;
  logic                              ready;
  logic [lsg_pkg::COL_W-1:0]         row_index;
  logic [lsg_pkg::COL_W-1:0]         col_index;
  logic signed [lsg_pkg::VAL_W-1:0]  entry_value;
  logic                              bad_column;
  logic                              last;

  modport source (output valid, output row_index, output col_index,
                  output entry_value, output bad_column, output last,
                  input ready);
  modport sink   (input valid, input row_index, input col_index,
                  input entry_value, input bad_column, input last,
                  output ready);
endinterface

`default_nettype wire

// File: design/laplacian_stencil_entry_generator.sv
// ---------------------------------------------------------------------------
// Laplacian stencil entry generator - top level
// Emits the nonzero entries of one column of the negated 2D/3D Laplacian.
// ---------------------------------------------------------------------------
// Each accepted column_index beat yields the column's nonzero entries in
// stencil order: the diagonal (4 in 2D, 6 in 3D) and then each in-grid
// neighbor (-1), the final beat flagged with last. A column at or beyond
// n^d, or any column when n is zero, yields one beat with bad_column set.
// A column yields 3 to 5 entries in 2D and 4 to 7 in 3D once n is at
// least 2, only the diagonal on a one-point grid, 1 for a bad column;
// all leave through the single result port of the emitter, and new
// columns are accepted while the previous one drains. From accept to
// first beat a column passes two front stages (n*n, then n*n*n), six
// remainder stages (three restoring steps of col mod n and col mod n*n
// each), the classify stage, the emitter's item register and its output
// register. Configuration may only be written while no column is in
// flight; grid_side above MAX_SIDE is clamped to MAX_SIDE, itself capped
// at 127.
// ---------------------------------------------------------------------------
`default_nettype none

module laplacian_stencil_entry_generator #(
  parameter int unsigned MAX_SIDE = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration write port
  input  wire logic                         cfg_we_i,
  input  wire lsg_pkg::cfg_idx_e            cfg_idx_i,
  input  wire logic [lsg_pkg::SIDE_W-1:0]   cfg_wdata_i,
  // streams
  lsg_in_if.sink                            in_i,
  lsg_out_if.source                         out_o
);
  import lsg_pkg::*;

  // clamp: the register can never exceed its own width
  localparam int unsigned SideMax    = (1 << SIDE_W) - 1;
  localparam int unsigned SideCapInt = (MAX_SIDE > SideMax) ? SideMax : MAX_SIDE;
  localparam logic [SIDE_W-1:0] SideCap = SIDE_W'(SideCapInt);

  logic [SIDE_W-1:0] grid_side_q, grid_side_d;
  logic              dims_mode_q, dims_mode_d;
  logic [SIDE_W-1:0] n_eff;

  // pipeline control: one global advance, stalls hold every stage
  logic              adv;
  logic              emit_ready;

  logic [MOD_STAGES:0] mv;
  pipe_t               mp [MOD_STAGES+1];
  logic                cls_v;
  item_t               cls_item;

  // config registers
  always_comb begin
    grid_side_d = grid_side_q;
    dims_mode_d = dims_mode_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRID_SIDE: grid_side_d = cfg_wdata_i;
        CFG_DIMS_MODE: dims_mode_d = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_side_q <= SIDE_W'(8);
      dims_mode_q <= 1'b0;
    end else begin
      grid_side_q <= grid_side_d;
      dims_mode_q <= dims_mode_d;
    end
  end

  assign n_eff = (grid_side_q > SideCap) ? SideCap : grid_side_q;

  // everything moves unless the classify stage holds an item the
  // emitter cannot take yet
  assign adv        = !cls_v || emit_ready;
  assign in_i.ready = adv;

  lsg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_v_i     (in_i.valid),
    .in_col_i   (in_i.column_index),
    .in_n_i     (n_eff),
    .in_three_i (dims_mode_q),
    .out_v_o    (mv[0]),
    .out_o      (mp[0])
  );

  // col mod n and col mod n*n, three quotient bits per stage
  for (genvar g = 0; g < MOD_STAGES; g++) begin : g_mod
    lsg_mod_stage #(
      .STAGE (g)
    ) u_mod (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .in_v_i  (mv[g]),
      .in_i    (mp[g]),
      .out_v_o (mv[g+1]),
      .out_o   (mp[g+1])
    );
  end

  lsg_classify u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .in_v_i  (mv[MOD_STAGES]),
    .in_i    (mp[MOD_STAGES]),
    .out_v_o (cls_v),
    .out_o   (cls_item)
  );

  lsg_emitter u_emitter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_v_i (cls_v),
    .item_i   (cls_item),
    .ready_o  (emit_ready),
    .out_o    (out_o)
  );

endmodule

`default_nettype wire

// File: design/lsg_front.sv
// ---------------------------------------------------------------------------
// Laplacian stencil entry generator - front stages
// Captures the column and forms n*n, then n*n*n, one multiply per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module lsg_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        adv_i,
  input  wire logic                        in_v_i,
  input  wire logic [lsg_pkg::COL_W-1:0]   in_col_i,
  input  wire logic [lsg_pkg::SIDE_W-1:0]  in_n_i,
  input  wire logic                        in_three_i,
  output logic                             out_v_o,
  output lsg_pkg::pipe_t                   out_o
);
  import lsg_pkg::*;

  logic              v1_q, v2_q;
  logic [COL_W-1:0]  col1_q;
  logic [SIDE_W-1:0] n1_q;
  logic [SQ_W-1:0]   nn1_q, nn1_d;
  logic              three1_q;
  pipe_t             p2_q, p2_d;

  assign nn1_d = SQ_W'(in_n_i) * SQ_W'(in_n_i);

  always_comb begin
    p2_d        = '0;
    p2_d.col    = col1_q;
    p2_d.n      = n1_q;
    p2_d.nn     = nn1_q;
    p2_d.nnn    = CUBE_W'(nn1_q) * CUBE_W'(n1_q);
    p2_d.three  = three1_q;
    p2_d.rem_n  = '0;
    p2_d.rem_nn = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= in_v_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      col1_q   <= in_col_i;
      n1_q     <= in_n_i;
      nn1_q    <= nn1_d;
      three1_q <= in_three_i;
      p2_q     <= p2_d;
    end
  end

  assign out_v_o = v2_q;
  assign out_o   = p2_q;

endmodule

`default_nettype wire

// File: design/lsg_mod_stage.sv
// ---------------------------------------------------------------------------
// Laplacian stencil entry generator - remainder stage
// Three restoring steps of col mod n and col mod n*n, then a register.
// ---------------------------------------------------------------------------
`default_nettype none

module lsg_mod_stage #(
  parameter int unsigned STAGE = 0
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     adv_i,
  input  wire logic     in_v_i,
  input  lsg_pkg::pipe_t in_i,
  output logic          out_v_o,
  output lsg_pkg::pipe_t out_o
);
  import lsg_pkg::*;

  localparam int unsigned TopBit = COL_W - 1 - STAGE * STEPS;

  logic  v_q;
  pipe_t p_q, p_d;

  always_comb begin
    logic [SQ_W-1:0] rn;
    logic [SQ_W-1:0] rnn;
    rn  = SQ_W'(in_i.rem_n);
    rnn = in_i.rem_nn;
    for (int s = 0; s < STEPS; s++) begin
      rn  = mod_step(rn,  in_i.col[TopBit - s], SQ_W'(in_i.n));
      rnn = mod_step(rnn, in_i.col[TopBit - s], in_i.nn);
    end
    p_d        = in_i;
    p_d.rem_n  = rn[SIDE_W-1:0];
    p_d.rem_nn = rnn;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (adv_i) begin
      v_q <= in_v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p_q <= p_d;
    end
  end

  assign out_v_o = v_q;
  assign out_o   = p_q;

endmodule

`default_nettype wire

// File: design/lsg_classify.sv
// ---------------------------------------------------------------------------
// Laplacian stencil entry generator - classify stage
// Range check, neighbor mask and neighbor rows in stencil order.
// ---------------------------------------------------------------------------
`default_nettype none

module lsg_classify (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      adv_i,
  input  wire logic      in_v_i,
  input  lsg_pkg::pipe_t in_i,
  output logic           out_v_o,
  output lsg_pkg::item_t out_o
);
  import lsg_pkg::*;

  logic  v_q;
  item_t it_q, it_d;

  always_comb begin
    logic [SUM_W-1:0]  col_w, n_w, nn_w, nnn_w, total;
    logic [SQ_W:0]     rnn_plus_n;
    logic [SIDE_W:0]   rn_plus_1;
    logic [COL_W-1:0]  c;
    logic              bad;
    c          = in_i.col;
    col_w      = SUM_W'(in_i.col);
    n_w        = SUM_W'(in_i.n);
    nn_w       = SUM_W'(in_i.nn);
    nnn_w      = SUM_W'(in_i.nnn);
    total      = in_i.three ? nnn_w : nn_w;
    rnn_plus_n = (SQ_W + 1)'(in_i.rem_nn) + (SQ_W + 1)'(in_i.n);
    rn_plus_1  = (SIDE_W + 1)'(in_i.rem_n) + (SIDE_W + 1)'(1);
    bad        = (in_i.n == '0) || (col_w >= total);

    it_d        = '0;
    it_d.col    = c;
    it_d.bad    = bad;
    it_d.center = bad ? BAD_VAL : (in_i.three ? CENTER_3D : CENTER_2D);
    it_d.rows[0] = bad ? '0 : c;
    if (bad) begin
      it_d.mask = SLOTS'(1);
    end else if (in_i.three) begin
      it_d.mask[0] = 1'b1;
      it_d.mask[1] = col_w >= nn_w;
      it_d.mask[2] = (col_w + nn_w) < nnn_w;
      it_d.mask[3] = (SQ_W + 1)'(in_i.rem_nn) >= (SQ_W + 1)'(in_i.n);
      it_d.mask[4] = rnn_plus_n < (SQ_W + 1)'(in_i.nn);
      it_d.mask[5] = in_i.rem_n != '0;
      it_d.mask[6] = rn_plus_1 < (SIDE_W + 1)'(in_i.n);
      it_d.rows[1] = c - COL_W'(in_i.nn);
      it_d.rows[2] = c + COL_W'(in_i.nn);
      it_d.rows[3] = c - COL_W'(in_i.n);
      it_d.rows[4] = c + COL_W'(in_i.n);
      it_d.rows[5] = c - COL_W'(1);
      it_d.rows[6] = c + COL_W'(1);
    end else begin
      it_d.mask[0] = 1'b1;
      it_d.mask[1] = in_i.rem_n != '0;
      it_d.mask[2] = rn_plus_1 < (SIDE_W + 1)'(in_i.n);
      it_d.mask[3] = col_w >= n_w;
      it_d.mask[4] = (col_w + n_w) < nn_w;
      it_d.rows[1] = c - COL_W'(1);
      it_d.rows[2] = c + COL_W'(1);
      it_d.rows[3] = c - COL_W'(in_i.n);
      it_d.rows[4] = c + COL_W'(in_i.n);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (adv_i) begin
      v_q <= in_v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      it_q <= it_d;
    end
  end

  assign out_v_o = v_q;
  assign out_o   = it_q;

endmodule

`default_nettype wire

// File: design/lsg_emitter.sv
// ---------------------------------------------------------------------------
// Laplacian stencil entry generator - entry emitter
// Walks the pending-slot mask of one column, one beat per ready cycle.
// ---------------------------------------------------------------------------
`default_nettype none
`include "laplacian_stencil_entry_generator_assert.svh"

module lsg_emitter (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      item_v_i,
  input  lsg_pkg::item_t item_i,
  output logic           ready_o,
  lsg_out_if.source      out_o
);
  import lsg_pkg::*;

  logic [SLOTS-1:0]        mask_q, mask_d, low_bit, rest;
  item_t                   item_q;
  logic                    slot_load, take;
  logic                    out_v_q, out_v_d;
  logic [COL_W-1:0]        out_row_q, out_col_q, row_sel;
  logic signed [VAL_W-1:0] out_val_q, val_sel;
  logic                    out_bad_q, out_last_q;

  assign low_bit   = mask_q & (~mask_q + SLOTS'(1));
  assign rest      = mask_q & ~low_bit;
  assign slot_load = (!out_v_q || out_o.ready) && (mask_q != '0);
  // free when no column is held or once it hands over its final entry
  assign ready_o   = (mask_q == '0) || (slot_load && (rest == '0));
  assign take      = item_v_i && ready_o;

  always_comb begin
    row_sel = item_q.rows[0];
    for (int s = 0; s < SLOTS; s++) begin
      if (low_bit[s]) begin
        row_sel = item_q.rows[s];
      end
    end
    val_sel = low_bit[0] ? item_q.center : NEIGHBOR_VAL;
  end

  always_comb begin
    mask_d = mask_q;
    if (take) begin
      mask_d = item_i.mask;
    end else if (slot_load) begin
      mask_d = rest;
    end
    out_v_d = out_v_q;
    if (slot_load) begin
      out_v_d = 1'b1;
    end else if (out_o.ready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      mask_q  <= mask_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
    if (slot_load) begin
      out_row_q  <= row_sel;
      out_col_q  <= item_q.col;
      out_val_q  <= val_sel;
      out_bad_q  <= item_q.bad;
      out_last_q <= (rest == '0);
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.row_index   = out_row_q;
  assign out_o.col_index   = out_col_q;
  assign out_o.entry_value = out_val_q;
  assign out_o.bad_column  = out_bad_q;
  assign out_o.last        = out_last_q;

  `LSG_ASSERT_IMP(a_bad_is_last, clk_i, rst_ni, out_v_q && out_bad_q, out_last_q, "bad beat not last")
  `LSG_ASSERT_IMP(a_bad_is_zero, clk_i, rst_ni, out_v_q && out_bad_q, (out_row_q == '0) && (out_val_q == '0), "bad beat carries data")
  `LSG_ASSERT_IMP(a_bad_one_slot, clk_i, rst_ni, (mask_q != '0) && item_q.bad, $onehot(mask_q), "bad column holds several slots")
  `LSG_ASSERT_NXT(a_drain, clk_i, rst_ni, slot_load && (rest == '0) && !take, mask_q == '0, "mask not empty after last beat")

endmodule

`default_nettype wire
